@@ rtl/fp_cvt_pkg.sv @@
// Shared types and constants for the single/half precision converter.
`timescale 1ns / 1ps
package fp_cvt_pkg;
    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;
    localparam logic [14:0] HALF_INF = 15'h7C00;
    localparam logic [14:0] HALF_QNAN = 15'h7E00;

    // Stage 1 to stage 2 payload
    typedef struct packed {
        logic        func;
        logic        sign;
        logic [7:0]  e8;
        logic [22:0] man;
        logic [15:0] half_in;
        logic [3:0]  lz;       // leading zeros of a subnormal half mantissa
    } s1_t;

    // Stage 2 to stage 3 payload
    typedef struct packed {
        logic        func;
        logic        sign;
        logic        special;   // result fixed, no rounding
        logic [14:0] fixed_val;
        logic [14:0] trunc;     // exponent and kept mantissa before rounding
        logic        round_up;
        logic [31:0] single_val;
    } s2_t;
endpackage

@@ rtl/fp_cvt_core.sv @@
// Three-stage conversion datapath with per-stage valid bits and stall.
`timescale 1ns / 1ps
module fp_cvt_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_func,
    input  logic [31:0] in_single,
    input  logic [15:0] in_half,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_half,
    output logic [31:0] out_single
);
    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;
    fp_cvt_pkg::s1_t s1_reg, s1_next;
    fp_cvt_pkg::s2_t s2_reg, s2_next;
    logic [15:0] h3_reg, h3_next;
    logic [31:0] f3_reg, f3_next;

    assign adv3 = !v3_reg || out_ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign in_ready = adv1;

    // Stage 1: split fields, count leading zeros of half mantissa
    always_comb begin
        s1_next.func = in_func;
        s1_next.sign = (in_func == fp_cvt_pkg::FUNC_ENCODE) ? in_single[31] : in_half[15];
        s1_next.e8 = in_single[30:23];
        s1_next.man = in_single[22:0];
        s1_next.half_in = in_half;
        s1_next.lz = 4'd10;
        for (int i = 0; i < 10; i++) begin
            if (in_half[i]) s1_next.lz = 4'(9 - i);
        end
    end

    // Stage 2: classify, align, round decision
    logic signed [9:0] e;
    logic [23:0] m;
    logic [4:0]  sh;
    logic [23:0] keep, drop, halfw, mask;
    logic [4:0]  he;
    logic [9:0]  hm, nm;
    always_comb begin
        e = $signed({2'b00, s1_reg.e8}) - 10'sd112;
        m = {1'b1, s1_reg.man};
        sh = 5'(10'sd14 - e);
        keep = '0; drop = '0; halfw = '0; mask = '0;
        he = '0; hm = '0; nm = '0;
        s2_next = '0;
        s2_next.func = s1_reg.func;
        s2_next.sign = s1_reg.sign;
        if (s1_reg.func == fp_cvt_pkg::FUNC_ENCODE) begin
            if (s1_reg.e8 == 8'hFF) begin
                s2_next.special = 1'b1;
                s2_next.fixed_val = (s1_reg.man != '0) ? fp_cvt_pkg::HALF_QNAN
                                                       : fp_cvt_pkg::HALF_INF;
            end else if (e < -10'sd10) begin
                s2_next.special = 1'b1;
            end else if (e >= 10'sd31) begin
                s2_next.special = 1'b1;
                s2_next.fixed_val = fp_cvt_pkg::HALF_INF;
            end else if (e <= 10'sd0) begin
                keep = m >> sh;
                mask = (24'd1 << sh) - 24'd1;
                drop = m & mask;
                halfw = 24'd1 << (sh - 5'd1);
                s2_next.trunc = keep[14:0];
                s2_next.round_up = (drop > halfw) || (drop == halfw && keep[0]);
            end else begin
                s2_next.trunc = {e[4:0], s1_reg.man[22:13]};
                s2_next.round_up = (s1_reg.man[12:0] > 13'h1000) ||
                                   (s1_reg.man[12:0] == 13'h1000 && s1_reg.man[13]);
            end
        end else begin
            he = s1_reg.half_in[14:10];
            hm = s1_reg.half_in[9:0];
            nm = 10'(hm << (s1_reg.lz + 4'd1));
            if (he == 5'h1F)
                s2_next.single_val = {s1_reg.sign, 8'hFF, hm, 13'd0};
            else if (he == 5'd0 && hm == '0)
                s2_next.single_val = {s1_reg.sign, 31'd0};
            else if (he == 5'd0)
                s2_next.single_val = {s1_reg.sign, 8'(8'd113 - 8'(s1_reg.lz) - 8'd1),
                                      nm, 13'd0};
            else
                s2_next.single_val = {s1_reg.sign, 8'(he) + 8'd112, hm, 13'd0};
        end
    end

    // Stage 3: apply rounding increment; a carry into exponent 31 lands on infinity
    always_comb begin
        h3_next = '0;
        f3_next = '0;
        if (s2_reg.func == fp_cvt_pkg::FUNC_ENCODE) begin
            if (s2_reg.special)
                h3_next = {s2_reg.sign, s2_reg.fixed_val};
            else
                h3_next = {s2_reg.sign, s2_reg.trunc + 15'(s2_reg.round_up)};
        end else begin
            f3_next = s2_reg.single_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) s1_reg <= s1_next;
        if (adv2) s2_reg <= s2_next;
        if (adv3) begin
            h3_reg <= h3_next;
            f3_reg <= f3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_half = h3_reg;
    assign out_single = f3_reg;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_half) && $stable(out_single))
        else $error("output changed under stall");
    a_one_side_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> (out_half == '0) || (out_single == '0))
        else $error("both result fields set");
    a_no_loss: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && !adv3 |=> v2_reg)
        else $error("stage 2 item dropped");
endmodule

@@ rtl/fp32_fp16_converter.sv @@
// Top level: IEEE single/half precision converter, streaming.
// Usage: present func with single_in (encode, func 0) or half_in (decode,
// func 1) on the s_ channel; one result per item appears on the m_ channel.
// Encode gives half_out with round-to-nearest-even and single_out zero;
// decode gives single_out exactly and half_out zero.
// Pipeline: three register stages (stage 1, stage 2, stage 3); m_valid rises once
// an item reaches the stage 3 register.
// Throughput: one item per cycle while m_ready is high; the three-stage
// datapath holds up to three items, one per stage register.
// Reset (aresetn low, synchronous) empties the pipeline; no other state.
// When the receiver stalls, the output holds and stages fill up; s_ready drops
// only once every stage holds an item and m_ready is low.
`timescale 1ns / 1ps
module fp32_fp16_converter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [31:0] s_single_in,
    input  logic [15:0] s_half_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_half_out,
    output logic [31:0] m_single_out
);
    fp_cvt_core u_core (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .in_func(s_func), .in_single(s_single_in), .in_half(s_half_in),
        .out_valid(m_valid), .out_ready(m_ready),
        .out_half(m_half_out), .out_single(m_single_out)
    );
endmodule

@@ tb/fp32_fp16_converter_test.sv @@
// Streaming testbench for the single/half precision converter.
`timescale 1ns / 1ps
module fp32_fp16_converter_test;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [15:0] half_val;
        logic [31:0] single_val;
    } cvt_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_func = fp_cvt_pkg::FUNC_ENCODE;
    logic [31:0] s_single_in = '0;
    logic [15:0] s_half_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_half_out;
    logic [31:0] m_single_out;

    cvt_result_t pending_results[$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          rx_no_stall = 1'b0;
    bit          tx_no_gap = 1'b0;

    fp32_fp16_converter u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_single_in(s_single_in), .s_half_in(s_half_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_half_out(m_half_out), .m_single_out(m_single_out)
    );

    always #5 aclk = ~aclk;

    function automatic logic [15:0] single_to_half(input logic [31:0] x);
        logic        sgn;
        logic [7:0]  ex8;
        logic [22:0] frac;
        int          ex;
        int          sh;
        logic [23:0] sig;
        logic [23:0] kept;
        logic [23:0] lost;
        logic [23:0] halfway;
        sgn = x[31];
        ex8 = x[30:23];
        frac = x[22:0];
        if (ex8 == 8'hFF)
            return (frac != '0) ? {sgn, fp_cvt_pkg::HALF_QNAN} : {sgn, fp_cvt_pkg::HALF_INF};
        ex = int'(ex8) - 112;
        if (ex <= 0) begin
            if (ex < -10)
                return {sgn, 15'd0};
            sig = {1'b1, frac};
            sh = 14 - ex;
            kept = sig >> sh;
            lost = sig & ((24'd1 << sh) - 24'd1);
            halfway = 24'd1 << (sh - 1);
            if (lost > halfway || (lost == halfway && kept[0]))
                kept++;
            return {sgn, kept[14:0]};
        end
        if (ex >= 31)
            return {sgn, fp_cvt_pkg::HALF_INF};
        kept = {14'd0, frac[22:13]};
        if (frac[12:0] > 13'h1000 || (frac[12:0] == 13'h1000 && kept[0])) begin
            kept++;
            if (kept == 24'h400) begin
                kept = '0;
                ex++;
                if (ex >= 31)
                    return {sgn, fp_cvt_pkg::HALF_INF};
            end
        end
        return {sgn, 5'(ex), kept[9:0]};
    endfunction

    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [4:0]  ex;
        logic [10:0] frac;
        logic [7:0]  shifts;
        ex = h[14:10];
        frac = {1'b0, h[9:0]};
        shifts = '0;
        if (ex == 5'h1F)
            return {h[15], 8'hFF, h[9:0], 13'd0};
        if (ex == 5'd0) begin
            if (frac == '0)
                return {h[15], 31'd0};
            while (!frac[10]) begin
                frac = frac << 1;
                shifts++;
            end
            return {h[15], 8'd113 - shifts, frac[9:0], 13'd0};
        end
        return {h[15], 8'(ex) + 8'd112, h[9:0], 13'd0};
    endfunction

    // valid stays high into the next item when there is no gap
    task automatic send_item(input logic fn, input logic [31:0] sv, input logic [15:0] hv);
        int gap;
        cvt_result_t exp_res;
        gap = tx_no_gap ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        if (fn == fp_cvt_pkg::FUNC_ENCODE) begin
            exp_res.half_val = single_to_half(sv);
            exp_res.single_val = '0;
        end else begin
            exp_res.half_val = '0;
            exp_res.single_val = half_to_single(hv);
        end
        s_valid <= 1'b1;
        s_func <= fn;
        s_single_in <= sv;
        s_half_in <= hv;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(exp_res);
    endtask

    // receiver stall, drawn afresh after every transfer
    initial begin
        int wait_cycles;
        @(posedge aclk iff aresetn);
        forever begin
            wait_cycles = rx_no_stall ? 0 : $urandom_range(0, 12);
            if (wait_cycles != 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin
        cvt_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected transfer: half_out %h single_out %h",
                       m_half_out, m_single_out);
                fail_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_half_out !== exp_res.half_val) begin
                    $error("half_out expected %h actual %h", exp_res.half_val, m_half_out);
                    fail_count++;
                end
                if (m_single_out !== exp_res.single_val) begin
                    $error("single_out expected %h actual %h",
                           exp_res.single_val, m_single_out);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_encode_corners();
        logic [31:0] vals[] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
            32'h7FC0_0000, 32'hFF80_0001, 32'h7FFF_FFFF, 32'h0000_0001,
            32'h477F_E000, 32'h477F_F000, 32'h4780_0000, 32'h3380_0000,
            32'h3380_0001, 32'h3400_0000, 32'h387F_F000, 32'h3F80_1000,
            32'h3F80_3000, 32'hC77F_EFFF, 32'h3300_0000};
        foreach (vals[i])
            send_item(fp_cvt_pkg::FUNC_ENCODE, vals[i], 16'hFFFF);
    endtask

    task automatic test_decode_corners();
        logic [15:0] vals[] = '{16'h0000, 16'h8000, 16'h0001, 16'h03FF, 16'h8200,
            16'h7C00, 16'hFC00, 16'h7C01, 16'hFE00, 16'h7BFF, 16'h0400, 16'hFFFF};
        foreach (vals[i])
            send_item(fp_cvt_pkg::FUNC_DECODE, 32'hFFFF_FFFF, vals[i]);
    endtask

    task automatic test_random_mix(input int count);
        logic [31:0] sv;
        logic [7:0]  ex;
        for (int n = 0; n < count; n++) begin
            if (n % 300 == 0) begin
                tx_no_gap = ($urandom_range(0, 3) == 0);
                rx_no_stall = ($urandom_range(0, 3) == 0);
            end
            sv = $urandom();
            // bias exponents to the half range and its edges now and then
            if ($urandom_range(0, 2) != 0) begin
                ex = 8'($urandom_range(95, 145));
                sv[30:23] = ex;
                if ($urandom_range(0, 5) == 0)
                    sv[12:0] = {1'b1, 12'd0};
            end
            send_item(logic'($urandom_range(0, 1)), sv, 16'($urandom()));
        end
        tx_no_gap = 1'b0;
        rx_no_stall = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_encode_corners();
        test_decode_corners();
        test_random_mix(1850);
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
